FILE: rtl/ptt_pkg.sv
// Shared types and codes for the periodic timer table.
`timescale 1ns / 1ps

package ptt_pkg;

   // Operation codes of an input item
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_FIRE     = 3'd0;
   localparam logic [2:0] KIND_ADDED    = 3'd1;
   localparam logic [2:0] KIND_FULL     = 3'd2;
   localparam logic [2:0] KIND_DELETED  = 3'd3;
   localparam logic [2:0] KIND_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  timer_id;
      logic [15:0] period;
      logic [15:0] repeat_count;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] fired_id;
      logic       last;
   } rsp_type;

   // One table entry as held in the memory
   typedef struct packed {
      logic [7:0]  ident;
      logic [15:0] period;
      logic [15:0] repeat_count;
      logic [15:0] runs;
      logic [15:0] phase;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

FILE: rtl/periodic_timer_table.sv
// Top level of the periodic timer table: entry memory and walk sequencer.
//
//  channel | ports                      | handshake
//  --------+----------------------------+-----------------------------------
//  request | start, busy, req_item      | taken when start high, busy low
//  result  | rsp_strobe, rsp_item       | one cycle per item, never stalled
//
// An add is handled while idle and its result appears on the next cycle; busy stays low.
// A tick or delete walks the entry memory through its single read port, one
// entry per cycle, with busy high through the walk and the finish state that
// follows it. The final result shows in the first cycle after busy falls.
// Reset clears the entry count and the sequencer; the memory is not cleared.
// The receiver cannot stall; a fire is held only until the next fire or the finish state.
`timescale 1ns / 1ps

module periodic_timer_table
   import ptt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Entry memory
   entry_type entry_mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_en;
   entry_type        wr_data;

   // Control registers
   state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] proc_ff, proc_in;
   logic [CNT_W-1:0] wptr_ff, wptr_in;
   logic       found_ff, found_in;
   logic       pend_valid_ff, pend_valid_in;
   logic [7:0] pend_id_ff, pend_id_in;
   logic       rsp_strobe_ff, rsp_strobe_in;
   req_type    req_ff, req_in;
   rsp_type    rsp_ff, rsp_in;

   // Walk datapath
   logic [16:0]      phase_inc;
   logic [16:0]      per_eff;
   logic             fire;
   logic [15:0]      runs_next;
   logic             keep;
   logic             match;
   logic [CNT_W-1:0] proc_next;
   logic             walk_last;
   entry_type        entry_new;
   logic             accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign proc_next = proc_ff + CNT_W'(1);
   assign walk_last = (proc_next == count_ff);

   // Work out the fate of the entry now in hand
   always_comb begin
      phase_inc = {1'b0, rd_data_ff.phase} + 17'd1;
      per_eff   = (rd_data_ff.period == 16'd0) ? 17'd1 : {1'b0, rd_data_ff.period};
      fire      = (req_ff.op == OP_TICK) && (phase_inc >= per_eff);
      runs_next = rd_data_ff.runs + 16'd1;
      match     = (req_ff.op == OP_DELETE) && !found_ff &&
                  (rd_data_ff.ident == req_ff.timer_id);
      entry_new = rd_data_ff;
      keep      = !match;
      if (req_ff.op == OP_TICK) begin
         entry_new.phase = fire ? 16'd0 : phase_inc[15:0];
         if (fire && (rd_data_ff.repeat_count != 16'd0)) begin
            entry_new.runs = runs_next;
            keep = (runs_next < rd_data_ff.repeat_count);
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      proc_in       = proc_ff;
      wptr_in       = wptr_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = wptr_ff[IDX_W-1:0];
      wr_data       = entry_new;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in        = req_item;
               proc_in       = '0;
               wptr_in       = '0;
               found_in      = 1'b0;
               pend_valid_in = 1'b0;
               case (req_item.op)
                  OP_ADD: begin
                     rsp_strobe_in   = 1'b1;
                     rsp_in.fired_id = req_item.timer_id;
                     rsp_in.last     = 1'b1;
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        rsp_in.kind = KIND_FULL;
                     end else begin
                        rsp_in.kind          = KIND_ADDED;
                        wr_en                = 1'b1;
                        wr_addr              = count_ff[IDX_W-1:0];
                        wr_data.ident        = req_item.timer_id;
                        wr_data.period       = (req_item.period == 16'd0) ? 16'd1
                                                                          : req_item.period;
                        wr_data.repeat_count = req_item.repeat_count;
                        wr_data.runs         = 16'd0;
                        wr_data.phase        = 16'd0;
                        count_in             = count_ff + CNT_W'(1);
                     end
                  end
                  OP_TICK, OP_DELETE: begin
                     state_in = (count_ff == '0) ? ST_FINISH : ST_WALK;
                  end
                  default: begin
                     // unused op: drop it
                  end
               endcase
            end
         end

         ST_WALK: begin
            // prefetch the next entry while this one is handled
            rd_addr = proc_next[IDX_W-1:0];
            if (keep) begin
               wr_en   = 1'b1;
               wptr_in = wptr_ff + CNT_W'(1);
            end
            if (match) begin
               found_in = 1'b1;
            end
            if (fire) begin
               // release the previous fire, hold this one until the next fire or the walk ends
               if (pend_valid_ff) begin
                  rsp_strobe_in   = 1'b1;
                  rsp_in.kind     = KIND_FIRE;
                  rsp_in.fired_id = pend_id_ff;
                  rsp_in.last     = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_id_in    = rd_data_ff.ident;
            end
            proc_in = proc_next;
            if (walk_last) begin
               count_in = keep ? (wptr_ff + CNT_W'(1)) : wptr_ff;
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            state_in = ST_IDLE;
            if (req_ff.op == OP_DELETE) begin
               rsp_strobe_in   = 1'b1;
               rsp_in.kind     = found_ff ? KIND_DELETED : KIND_NOTFOUND;
               rsp_in.fired_id = req_ff.timer_id;
               rsp_in.last     = 1'b1;
            end else if (pend_valid_ff) begin
               rsp_strobe_in   = 1'b1;
               rsp_in.kind     = KIND_FIRE;
               rsp_in.fired_id = pend_id_ff;
               rsp_in.last     = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      proc_ff    <= proc_in;
      wptr_ff    <= wptr_in;
      pend_id_ff <= pend_id_in;
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

FILE: rtl/ptt_checker.sv
// Port-level checker for the periodic timer table, with its bind.
`timescale 1ns / 1ps

module ptt_checker
   import ptt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // Reset leaves the block ready for an item
   assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   // An add answers on the next cycle with its own id
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.op == OP_ADD) |=>
         (rsp_strobe && rsp_item.last && $past(req_item.timer_id) == rsp_item.fired_id &&
          (rsp_item.kind == KIND_ADDED || rsp_item.kind == KIND_FULL)))
      else $error("add result missing or wrong");

   // A tick or delete holds the block busy while it walks
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.op == OP_TICK || req_item.op == OP_DELETE)) |=> busy)
      else $error("walk did not raise busy");

   // Only a fire can be a non-final item, and never once the block is idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |-> (busy && rsp_item.kind == KIND_FIRE))
      else $error("non-final item out of place");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the periodic timer table: directed and random items.
`timescale 1ns / 1ps

import ptt_pkg::*;

localparam int TIMER_SLOTS = 16;

// Tracks the timer table and holds the events the block still owes
class timer_table_tracker;
   entry_type   slots[TIMER_SLOTS];
   int unsigned live_count;
   rsp_type     due_events[$];
   int unsigned errors;

   function new();
      live_count = 0;
      errors = 0;
   endfunction

   function int unsigned pending();
      return due_events.size();
   endfunction

   // Remove one entry and close the gap behind it
   function void drop_entry(int unsigned pos);
      int unsigned j;
      for (j = pos; j + 1 < live_count; j++) begin
         slots[j] = slots[j + 1];
      end
      live_count--;
   endfunction

   // Advance the table by one accepted item and queue the events it causes
   function void apply_item(req_type it);
      rsp_type     ev;
      logic [7:0]  fired[$];
      int unsigned i;
      bit          hit;
      bit          removed;
      ev.last = 1'b1;
      ev.fired_id = it.timer_id;
      case (it.op)
         OP_ADD: begin
            if (live_count >= TIMER_SLOTS) begin
               ev.kind = KIND_FULL;
            end else begin
               slots[live_count].ident = it.timer_id;
               slots[live_count].period = (it.period == 16'd0) ? 16'd1 : it.period;
               slots[live_count].repeat_count = it.repeat_count;
               slots[live_count].runs = 16'd0;
               slots[live_count].phase = 16'd0;
               live_count++;
               ev.kind = KIND_ADDED;
            end
            due_events.push_back(ev);
         end
         OP_DELETE: begin
            hit = 1'b0;
            for (i = 0; i < live_count && !hit; i++) begin
               if (slots[i].ident == it.timer_id) begin
                  drop_entry(i);
                  hit = 1'b1;
               end
            end
            ev.kind = hit ? KIND_DELETED : KIND_NOTFOUND;
            due_events.push_back(ev);
         end
         OP_TICK: begin
            // walk in table order; a removed entry lets the next one slide into place
            i = 0;
            while (i < live_count) begin
               removed = 1'b0;
               if (int'(slots[i].phase) + 1 >= int'(slots[i].period)) begin
                  slots[i].phase = 16'd0;
                  fired.push_back(slots[i].ident);
                  if (slots[i].repeat_count != 16'd0) begin
                     slots[i].runs = slots[i].runs + 16'd1;
                     if (slots[i].runs >= slots[i].repeat_count) begin
                        drop_entry(i);
                        removed = 1'b1;
                     end
                  end
               end else begin
                  slots[i].phase = slots[i].phase + 16'd1;
               end
               if (!removed) i++;
            end
            foreach (fired[k]) begin
               ev.kind = KIND_FIRE;
               ev.fired_id = fired[k];
               ev.last = (k == fired.size() - 1);
               due_events.push_back(ev);
            end
         end
         default: ;
      endcase
   endfunction

   // Compare one result with the oldest event owed
   function void match_event(rsp_type got);
      rsp_type want;
      if (due_events.size() == 0) begin
         $display("%0t: unexpected result kind %0d id %0d last %0d",
                  $time, got.kind, got.fired_id, got.last);
         errors++;
      end else begin
         want = due_events.pop_front();
         if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
             got.last !== want.last) begin
            $display("%0t: mismatch expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                     $time, want.kind, want.fired_id, want.last,
                     got.kind, got.fired_id, got.last);
            errors++;
         end
      end
   endfunction
endclass

module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   timer_table_tracker tracker;
   bit no_gaps = 1'b0;
   int idle_cycles = 0;

   periodic_timer_table #(
      .TABLE_DEPTH(TIMER_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   always #6 clock = ~clock;

   // Check results first, then note the item taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.match_event(rsp_item);
         if (start && !busy) tracker.apply_item(req_item);
      end
   end

   // Stop a hung run: count edges with no item taken and no result seen
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one item, at times after a random gap, and hold it until taken
   task automatic send_item(input req_type it);
      int unsigned gap;
      int unsigned pick;
      logic [63:0] junk;
      gap = 0;
      if (!no_gaps) begin
         pick = $urandom_range(0, 99);
         if (pick >= 90) gap = $urandom_range(10, 40);
         else if (pick >= 60) gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         junk = {$urandom, $urandom};
         start <= 1'b0;
         req_item <= junk[$bits(req_type)-1:0];
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_fields(input logic [1:0] op, input logic [7:0] id,
                              input logic [15:0] per, input logic [15:0] rep);
      req_type it;
      it.op = op;
      it.timer_id = id;
      it.period = per;
      it.repeat_count = rep;
      send_item(it);
   endtask

   // Hold off until every owed result has arrived
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   initial begin
      req_type     it;
      int unsigned pick;
      int unsigned counted;
      int          add_pct[4];
      int          del_pct[4];
      tracker = new();
      add_pct = '{40, 25, 15, 30};
      del_pct = '{15, 20, 40, 20};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, unused op, unknown id
      send_fields(OP_TICK, 8'h00, 16'd0, 16'd0);
      send_fields(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_fields(OP_DELETE, 8'h07, 16'd0, 16'd0);
      // zero period, extremes, finite timers and a duplicate id
      send_fields(OP_ADD, 8'h00, 16'd0, 16'd0);
      send_fields(OP_ADD, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_fields(OP_ADD, 8'hAA, 16'd1, 16'd1);
      send_fields(OP_ADD, 8'h55, 16'd2, 16'd2);
      send_fields(OP_ADD, 8'h00, 16'd3, 16'd0);
      repeat (4) send_fields(OP_TICK, 8'h00, 16'd0, 16'd0);
      // delete removes the first of two equal ids
      send_fields(OP_DELETE, 8'h00, 16'd0, 16'd0);
      // fill the table, overflow it, then fire every period-1 slot in one tick
      for (int k = 0; k < TIMER_SLOTS - 1; k++) begin
         send_fields(OP_ADD, 8'(k * 17), 16'd1, 16'(k % 2));
      end
      send_fields(OP_ADD, 8'h3C, 16'd1, 16'd1);
      send_fields(OP_TICK, 8'h00, 16'd0, 16'd0);
      drain();

      // random phases, each leaning a different way on adds and deletes
      for (int ph = 0; ph < 4; ph++) begin
         counted = 0;
         no_gaps = (ph == 0);
         while (counted < 105) begin
            if (ph != 0 && counted % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            it.timer_id = (pick < 80) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 70) it.period = 16'($urandom_range(0, 6));
            else if (pick < 90) it.period = 16'($urandom_range(7, 40));
            else it.period = 16'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 30) it.repeat_count = 16'd0;
            else if (pick < 80) it.repeat_count = 16'($urandom_range(1, 4));
            else it.repeat_count = 16'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < add_pct[ph]) it.op = OP_ADD;
            else if (pick < add_pct[ph] + del_pct[ph]) it.op = OP_DELETE;
            else if (pick < 96) it.op = OP_TICK;
            else it.op = OP_UNUSED;
            send_item(it);
            if (it.op != OP_UNUSED) counted++;
         end
         drain();
      end

      // let any walk still in flight finish, then judge the run
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, tracker.pending());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
